FILE: sv/cpvd_pkg.sv
// Package with shared types and constants for the polyline vertex decoder.
`default_nettype none
package cpvd_pkg;
	localparam logic [1:0] CMD_BEGIN = 2'd0;
	localparam logic [1:0] CMD_END   = 2'd1;
	localparam logic [1:0] CMD_DELTA = 2'd2;
	localparam logic [1:0] CMD_PLAIN = 2'd3;
	localparam logic [7:0] TERMINATOR = 8'h80;

	typedef struct packed {
		logic [1:0]         command;
		logic               new_series;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
		logic signed [15:0] step_x;
		logic signed [15:0] step_y;
		logic signed [15:0] step_z;
		logic signed [7:0]  delta_x;
		logic signed [7:0]  delta_y;
		logic signed [7:0]  delta_z;
	} item_t;
endpackage
`default_nettype wire

FILE: sv/cpvd_front.sv
// Input stage and two-entry queue that decouples item intake from the datapath.
`default_nettype none
module cpvd_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire cpvd_pkg::item_t in_item,
	output logic                 q_valid,
	input  wire logic            q_ready,
	output cpvd_pkg::item_t      q_item
);
	import cpvd_pkg::*;

	item_t      mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = mem_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

FILE: sv/cpvd_rem.sv
// Restoring divider giving the C-style remainder of a signed value by a magnitude.
`default_nettype none
module cpvd_rem #(
	parameter int COORD_BITS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic signed [COORD_BITS-1:0] dividend,
	input  wire logic [15:0]                  divisor,
	output logic                              done,
	output logic signed [COORD_BITS-1:0]      remainder
);
	localparam int CW = $clog2(COORD_BITS + 1);

	logic [COORD_BITS-1:0] mag_q;
	logic [15:0]           rem_q;
	logic [15:0]           div_q;
	logic                  neg_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic [16:0]           trial;
	logic [16:0]           shifted;
	logic [COORD_BITS-1:0] rem_ext;

	assign shifted = {rem_q, mag_q[COORD_BITS-1]};
	assign trial = shifted - {1'b0, div_q};
	assign done = busy_q && (cnt_q == CW'(0));
	assign rem_ext = COORD_BITS'(rem_q);
	assign remainder = neg_q ? -rem_ext : rem_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CW'(COORD_BITS);
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[COORD_BITS-1];
			mag_q <= dividend[COORD_BITS-1] ? -dividend : dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q && !done) begin
			mag_q <= {mag_q[COORD_BITS-2:0], 1'b0};
			rem_q <= trial[16] ? shifted[15:0] : trial[15:0];
		end
	end
endmodule
`default_nettype wire

FILE: sv/cpvd_back.sv
// Decode datapath: running coordinates, rounding sequencer and output register.
`default_nettype none
module cpvd_back #(
	parameter int COORD_BITS = 32,
	parameter int COUNT_BITS = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	output logic                 q_ready,
	input  wire cpvd_pkg::item_t q_item,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic signed [31:0]   vertex_x,
	output logic signed [31:0]   vertex_y,
	output logic signed [31:0]   vertex_z,
	output logic [15:0]          vertex_index,
	output logic                 line_end
);
	import cpvd_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam int CB = COORD_BITS;

	logic [1:0]           state_q;
	logic [1:0]           axis_q;
	logic [CB-1:0]        run_q [3];
	logic signed [15:0]   fac_q [3];
	logic [CB-1:0]        start_q [3];
	logic [CB-1:0]        end_q [3];
	logic [CB-1:0]        pend_q [3];
	logic [CB-1:0]        prev_q [3];
	logic [COUNT_BITS-1:0] pend_idx_q;
	logic                 pend_v_q;
	logic                 prev_v_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [CB-1:0]        o_pt_q [3];
	logic [COUNT_BITS-1:0] o_idx_q;
	logic                 o_end_q;
	logic                 o_v_q;

	logic                 take;
	logic                 out_free;
	logic                 load_out;
	logic [CB-1:0]        p [3];
	logic [CB-1:0]        nrun [3];
	logic [15:0]          mag [3];
	logic                 rem_start;
	logic                 rem_done;
	logic signed [CB-1:0] rem;
	logic [16:0]          g17;
	logic signed [CB:0]   twice;
	logic [CB-1:0]        rounded;
	logic [COUNT_BITS-1:0] cnt_base;
	logic                 same;
	logic                 is_term;

	assign p[0] = CB'(q_item.coord_x);
	assign p[1] = CB'(q_item.coord_y);
	assign p[2] = CB'(q_item.coord_z);
	assign out_free = !o_v_q || out_ready;
	assign q_ready = (state_q == ST_IDLE) && out_free;
	assign take = q_valid && q_ready;
	assign is_term = (q_item.delta_x == TERMINATOR);
	assign cnt_base = q_item.new_series ? '0 : count_q;
	assign same = prev_v_q && !q_item.new_series && (prev_q[0] == p[0]) &&
		(prev_q[1] == p[1]) && (prev_q[2] == p[2]);
	assign load_out = take && (((q_item.command == CMD_BEGIN) && (cnt_base == '0)) ||
		((q_item.command == CMD_DELTA) && (is_term || pend_v_q)) ||
		((q_item.command == CMD_PLAIN) && !same));

	for (genvar i = 0; i < 3; i++) begin : g_ax
		assign mag[i] = fac_q[i][15] ? 16'(-fac_q[i]) : 16'(fac_q[i]);
	end

	assign nrun[0] = run_q[0] + CB'(q_item.delta_x * fac_q[0]);
	assign nrun[1] = run_q[1] + CB'(q_item.delta_y * fac_q[1]);
	assign nrun[2] = (fac_q[2] != 16'sd0) ? run_q[2] + CB'(q_item.delta_z * fac_q[2])
		: run_q[2];

	assign rem_start = (state_q == ST_START);
	assign g17 = {1'b0, mag[axis_q]};
	assign twice = {rem, 1'b0};
	assign rounded = (twice <= $signed((CB+1)'(g17))) ? start_q[axis_q] - rem
		: start_q[axis_q] - rem + CB'(g17);

	cpvd_rem #(.COORD_BITS(COORD_BITS)) u_rem (
		.clk(clk), .arst_n(arst_n), .start(rem_start),
		.dividend(start_q[axis_q]), .divisor(mag[axis_q]),
		.done(rem_done), .remainder(rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q <= 2'd0;
			pend_v_q <= 1'b0;
			prev_v_q <= 1'b0;
			count_q <= '0;
			o_v_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				run_q[i] <= '0;
				fac_q[i] <= '0;
				end_q[i] <= '0;
				pend_q[i] <= '0;
				prev_q[i] <= '0;
				start_q[i] <= '0;
			end
			pend_idx_q <= '0;
		end else begin
			if (load_out) begin
				o_v_q <= 1'b1;
			end else if (out_ready) begin
				o_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						unique case (q_item.command)
							CMD_BEGIN: begin
								pend_v_q <= 1'b0;
								if (q_item.new_series) begin
									prev_v_q <= 1'b0;
								end
								fac_q[0] <= q_item.step_x;
								fac_q[1] <= q_item.step_y;
								fac_q[2] <= q_item.step_z;
								for (int i = 0; i < 3; i++) begin
									start_q[i] <= p[i];
									run_q[i] <= p[i];
								end
								count_q <= (cnt_base == '0) ? COUNT_BITS'(1) : cnt_base;
								if (cnt_base == '0) begin
									o_pt_q <= p;
									o_idx_q <= '0;
									o_end_q <= 1'b0;
								end
								axis_q <= 2'd0;
								state_q <= ST_START;
							end
							CMD_END: begin
								end_q <= p;
							end
							CMD_DELTA: begin
								if (is_term) begin
									o_pt_q <= end_q;
									o_end_q <= 1'b1;
									pend_v_q <= 1'b0;
									if (pend_v_q) begin
										o_idx_q <= pend_idx_q;
									end else begin
										o_idx_q <= count_q;
										if (count_q != CNT_MAX) begin
											count_q <= count_q + 1'b1;
										end
									end
								end else begin
									if (pend_v_q) begin
										o_pt_q <= pend_q;
										o_idx_q <= pend_idx_q;
										o_end_q <= 1'b0;
									end
									run_q <= nrun;
									pend_q <= nrun;
									pend_idx_q <= count_q;
									pend_v_q <= 1'b1;
									if (count_q != CNT_MAX) begin
										count_q <= count_q + 1'b1;
									end
								end
							end
							CMD_PLAIN: begin
								pend_v_q <= 1'b0;
								count_q <= (!same && (cnt_base != CNT_MAX)) ?
									cnt_base + 1'b1 : cnt_base;
								if (!same) begin
									prev_q <= p;
									prev_v_q <= 1'b1;
									o_pt_q <= p;
									o_idx_q <= cnt_base;
									o_end_q <= 1'b0;
								end
							end
							default: ;
						endcase
					end
				end
				ST_START: begin
					if (mag[axis_q] == 16'd0) begin
						if (axis_q == 2'd2) begin
							state_q <= ST_IDLE;
						end
						axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (rem_done) begin
						run_q[axis_q] <= rounded;
						axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
						state_q <= (axis_q == 2'd2) ? ST_IDLE : ST_START;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = o_v_q;
	assign vertex_x = 32'(signed'(o_pt_q[0]));
	assign vertex_y = 32'(signed'(o_pt_q[1]));
	assign vertex_z = 32'(signed'(o_pt_q[2]));
	assign vertex_index = 16'(o_idx_q);
	assign line_end = o_end_q;
endmodule
`default_nettype wire

FILE: sv/compressed_polyline_vertex_decoder.sv
// Top level of the compressed polyline vertex decoder.
// Input words carry one command each (begin, end coordinate, delta, plain vertex)
// over a valid/ready channel; decoded vertices leave over a second valid/ready
// channel with their index and a line-end flag, at most one per input word.
// A two-word queue takes input while the datapath works or the output stalls.
// End, delta and plain words leave the datapath idle, ready for the next word; a
// result is registered in the cycle after the word leaves the queue.
// A begin word occupies the datapath while the shared one-bit-per-cycle
// remainder unit runs once per axis with a nonzero step factor, passing
// through ST_START and ST_WAIT; an axis with a zero factor only passes
// through ST_START.
// When the receiver stalls the output register holds its vertex and the
// datapath stops after that; the queue then fills and input ready falls.
// Reset clears the running coordinates, factors, counters and all valid flags.
`default_nettype none
module compressed_polyline_vertex_decoder #(
	parameter int COORD_BITS = 32,
	parameter int COUNT_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         command,
	input  wire logic               new_series,
	input  wire logic signed [31:0] coord_x,
	input  wire logic signed [31:0] coord_y,
	input  wire logic signed [31:0] coord_z,
	input  wire logic signed [15:0] step_x,
	input  wire logic signed [15:0] step_y,
	input  wire logic signed [15:0] step_z,
	input  wire logic signed [7:0]  delta_x,
	input  wire logic signed [7:0]  delta_y,
	input  wire logic signed [7:0]  delta_z,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      vertex_x,
	output logic signed [31:0]      vertex_y,
	output logic signed [31:0]      vertex_z,
	output logic [15:0]             vertex_index,
	output logic                    line_end
);
	import cpvd_pkg::*;

	item_t in_item;
	item_t q_item;
	logic  q_valid;
	logic  q_ready;

	assign in_item = '{command, new_series, coord_x, coord_y, coord_z,
		step_x, step_y, step_z, delta_x, delta_y, delta_z};

	cpvd_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	cpvd_back #(.COORD_BITS(COORD_BITS), .COUNT_BITS(COUNT_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready),
		.q_item(q_item), .out_valid(out_valid), .out_ready(out_ready),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
		.vertex_index(vertex_index), .line_end(line_end)
	);
endmodule
`default_nettype wire

FILE: sv/cpvd_checker.sv
// Port-level checker for the polyline vertex decoder and its bind.
`default_nettype none
module cpvd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] vertex_x,
	input wire logic [15:0] vertex_index,
	input wire logic        line_end
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(vertex_x) &&
		$stable(vertex_index))
		else $error("output word changed while stalled");
	a_end_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(line_end))
		else $error("line end flag changed while stalled");
	a_no_out_reset: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("output valid after reset");
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input word withdrawn before acceptance");
endmodule

bind compressed_polyline_vertex_decoder cpvd_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .vertex_x(vertex_x[15:0]),
	.vertex_index(vertex_index), .line_end(line_end)
);
`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking testbench for the compressed polyline vertex decoder.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import cpvd_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 150;
	localparam int RANDOM_WORDS = 950;
	localparam int STEADY_WORDS = 120;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [15:0] index;
		logic fin;
	} vertex_t;

	class vertex_scoreboard;
		logic signed [31:0] run_x, run_y, run_z;
		logic signed [15:0] fac_x, fac_y, fac_z;
		logic signed [31:0] end_x, end_y, end_z;
		logic held_valid;
		vertex_t held_vertex;
		logic signed [31:0] last_x, last_y, last_z;
		logic last_valid;
		logic [15:0] count;
		vertex_t awaited[$];
		int matched;

		function new();
			run_x = 0; run_y = 0; run_z = 0;
			fac_x = 0; fac_y = 0; fac_z = 0;
			end_x = 0; end_y = 0; end_z = 0;
			held_valid = 0; last_valid = 0; count = 0;
			last_x = 0; last_y = 0; last_z = 0;
			held_vertex = '{0, 0, 0, 0, 0};
			matched = 0;
		endfunction

		function logic signed [31:0] snap(logic signed [31:0] c, logic signed [15:0] f);
			longint cl, g, m, r;
			cl = c;
			g = (f < 0) ? -longint'(f) : longint'(f);
			if (g == 0)
				return c;
			m = cl % g;
			r = (m * 2 <= g) ? cl - m : cl - m + g;
			return r[31:0];
		endfunction

		function logic [15:0] next_index();
			logic [15:0] idx;
			idx = count;
			if (count != 16'hFFFF)
				count++;
			return idx;
		endfunction

		function void push(logic signed [31:0] x, logic signed [31:0] y,
				logic signed [31:0] z, logic [15:0] idx, logic fin);
			vertex_t v;
			v.x = x; v.y = y; v.z = z; v.index = idx; v.fin = fin;
			awaited.push_back(v);
		endfunction

		function void note_word(item_t w);
			longint sum;
			case (w.command)
				CMD_BEGIN: begin
					held_valid = 0;
					if (w.new_series) begin
						count = 0;
						last_valid = 0;
					end
					fac_x = w.step_x; fac_y = w.step_y; fac_z = w.step_z;
					if (count == 0) begin
						push(w.coord_x, w.coord_y, w.coord_z, 0, 0);
						count = 1;
					end
					run_x = snap(w.coord_x, fac_x);
					run_y = snap(w.coord_y, fac_y);
					run_z = snap(w.coord_z, fac_z);
				end
				CMD_END: begin
					end_x = w.coord_x; end_y = w.coord_y; end_z = w.coord_z;
				end
				CMD_DELTA: begin
					if (w.delta_x == $signed(TERMINATOR)) begin
						if (held_valid) begin
							push(end_x, end_y, end_z, held_vertex.index, 1);
							held_valid = 0;
						end else begin
							push(end_x, end_y, end_z, next_index(), 1);
						end
					end else begin
						if (held_valid)
							awaited.push_back(held_vertex);
						sum = longint'(run_x) + longint'(w.delta_x) * longint'(fac_x);
						run_x = sum[31:0];
						sum = longint'(run_y) + longint'(w.delta_y) * longint'(fac_y);
						run_y = sum[31:0];
						if (fac_z != 0) begin
							sum = longint'(run_z) + longint'(w.delta_z) * longint'(fac_z);
							run_z = sum[31:0];
						end
						held_vertex.x = run_x; held_vertex.y = run_y; held_vertex.z = run_z;
						held_vertex.fin = 0;
						held_vertex.index = next_index();
						held_valid = 1;
					end
				end
				default: begin
					held_valid = 0;
					if (w.new_series) begin
						count = 0;
						last_valid = 0;
					end
					if (!(last_valid && last_x == w.coord_x && last_y == w.coord_y &&
							last_z == w.coord_z)) begin
						last_x = w.coord_x; last_y = w.coord_y; last_z = w.coord_z;
						last_valid = 1;
						push(w.coord_x, w.coord_y, w.coord_z, next_index(), 0);
					end
				end
			endcase
		endfunction

		function string check_vertex(vertex_t got);
			vertex_t e;
			if (awaited.size() == 0)
				return $sformatf("unexpected vertex %0d,%0d,%0d idx %0d end %0d",
					got.x, got.y, got.z, got.index, got.fin);
			e = awaited.pop_front();
			if (got.x !== e.x || got.y !== e.y || got.z !== e.z || got.index !== e.index ||
					got.fin !== e.fin)
				return $sformatf("got %0d,%0d,%0d idx %0d end %0d, want %0d,%0d,%0d idx %0d end %0d",
					got.x, got.y, got.z, got.index, got.fin,
					e.x, e.y, e.z, e.index, e.fin);
			matched++;
			return "";
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] command = CMD_DELTA;
	logic new_series = 0;
	logic signed [31:0] coord_x = 0, coord_y = 0, coord_z = 0;
	logic signed [15:0] step_x = 0, step_y = 0, step_z = 0;
	logic signed [7:0] delta_x = 0, delta_y = 0, delta_z = 0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [31:0] vertex_x, vertex_y, vertex_z;
	logic [15:0] vertex_index;
	logic line_end;

	vertex_scoreboard sb = new();
	int errors = 0;
	int words_sent = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	bit steady = 0;
	bit rx_free = 0;
	int rx_mode = 0;
	int rx_phase = 0;

	compressed_polyline_vertex_decoder uut (.*);

	always #5 clk = ~clk;

	task automatic report(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	always @(posedge clk) begin
		vertex_t v;
		string msg;
		if (out_valid && out_ready) begin
			v.x = vertex_x; v.y = vertex_y; v.z = vertex_z;
			v.index = vertex_index; v.fin = line_end;
			msg = sb.check_vertex(v);
			if (msg != "")
				report(msg);
		end
		rx_phase++;
		if (rx_phase % 200 == 0)
			rx_mode = $urandom_range(0, 3);
		if (!arst_n)
			out_ready <= 0;
		else if (rx_free || rx_mode == 0)
			out_ready <= 1;
		else if (rx_mode == 1)
			out_ready <= (rx_phase % 7) < 4;
		else if (rx_mode == 2)
			out_ready <= ($urandom_range(0, 9) < 3);
		else
			out_ready <= ($urandom_range(0, 9) < 8);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d vertices awaited", sb.awaited.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_word(item_t w);
		int gap;
		command <= w.command; new_series <= w.new_series;
		coord_x <= w.coord_x; coord_y <= w.coord_y; coord_z <= w.coord_z;
		step_x <= w.step_x; step_y <= w.step_y; step_z <= w.step_z;
		delta_x <= w.delta_x; delta_y <= w.delta_y; delta_z <= w.delta_z;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		sb.note_word(w);
		words_sent++;
		gap = 0;
		if (!steady) begin
			if (burst_left > 0)
				burst_left--;
			else begin
				burst_left = $urandom_range(0, 12);
				gap = $urandom_range(1, 6);
			end
		end
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [31:0] any_coord();
		case ($urandom_range(0, 5))
			0: return 32'sh80000000;
			1: return 32'sh7FFFFFFF;
			2: return $signed($urandom_range(0, 200)) - 100;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [15:0] any_step();
		case ($urandom_range(0, 5))
			0: return 16'sd0;
			1: return $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
			2, 3: return 16'($signed($urandom_range(0, 40)) - 20);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic item_t word(logic [1:0] cmd, logic fresh, logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z);
		item_t w;
		w = '0;
		w.command = cmd; w.new_series = fresh;
		w.coord_x = x; w.coord_y = y; w.coord_z = z;
		w.step_x = 1; w.step_y = 1;
		return w;
	endfunction

	function automatic item_t begin_word(logic fresh, logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z, logic signed [15:0] fx,
			logic signed [15:0] fy, logic signed [15:0] fz);
		item_t w;
		w = word(CMD_BEGIN, fresh, x, y, z);
		w.step_x = fx; w.step_y = fy; w.step_z = fz;
		return w;
	endfunction

	function automatic item_t delta_word(logic signed [7:0] dx, logic signed [7:0] dy,
			logic signed [7:0] dz);
		item_t w;
		w = word(CMD_DELTA, 0, 0, 0, 0);
		w.delta_x = dx; w.delta_y = dy; w.delta_z = dz;
		return w;
	endfunction

	function automatic item_t random_delta();
		logic signed [7:0] dx;
		dx = 8'($urandom);
		if (dx == $signed(TERMINATOR))
			dx = 127;
		return delta_word(dx, 8'($urandom), 8'($urandom));
	endfunction

	task automatic random_line();
		int n;
		send_word(begin_word(1'($urandom), any_coord(), any_coord(), any_coord(),
			any_step(), any_step(), any_step()));
		send_word(word(CMD_END, 1'($urandom), any_coord(), any_coord(), any_coord()));
		n = $urandom_range(0, 12);
		repeat (n) send_word(random_delta());
		if ($urandom_range(0, 9) != 0)
			send_word(delta_word($signed(TERMINATOR), 8'($urandom), 8'($urandom)));
	endtask

	task automatic random_plain_run();
		item_t w;
		int n;
		n = $urandom_range(1, 6);
		w = word(CMD_PLAIN, $urandom_range(0, 3) == 0, any_coord(), any_coord(), any_coord());
		repeat (n) begin
			send_word(w);
			w.new_series = 0;
			if ($urandom_range(0, 2) == 0)
				w.coord_x = any_coord();
			if ($urandom_range(0, 3) == 0)
				w.coord_z = any_coord();
		end
	endtask

	task automatic random_noise();
		item_t w;
		w.command = 2'($urandom); w.new_series = 1'($urandom);
		w.coord_x = $urandom; w.coord_y = $urandom; w.coord_z = $urandom;
		w.step_x = 16'($urandom); w.step_y = 16'($urandom); w.step_z = 16'($urandom);
		w.delta_x = 8'($urandom); w.delta_y = 8'($urandom); w.delta_z = 8'($urandom);
		send_word(w);
	endtask

	task automatic random_mix();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			random_line();
		else if (pick < 9)
			random_plain_run();
		else
			random_noise();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: deltas and terminator before any begin, rounding ties and extremes.
		send_word(delta_word(3, -5, 7));
		send_word(delta_word($signed(TERMINATOR), 0, 0));
		send_word(word(CMD_END, 0, 32'sh7FFFFFFF, 32'sh80000000, -1));
		send_word(delta_word($signed(TERMINATOR), -128, -128));
		send_word(begin_word(1, 5, -5, 15, 10, -10, 10));
		send_word(delta_word(127, -128, 127));
		send_word(delta_word(-127, 127, -128));
		send_word(delta_word($signed(TERMINATOR), 1, 1));
		send_word(begin_word(0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
			16'sh7FFF, 16'sh8000, 0));
		send_word(delta_word(127, 127, 127));
		send_word(begin_word(1, -7, 7, 6, 3, 3, -4));
		send_word(delta_word(1, 1, 1));
		send_word(word(CMD_PLAIN, 0, 1, 2, 3));
		send_word(word(CMD_PLAIN, 0, 1, 2, 3));
		send_word(word(CMD_PLAIN, 1, 1, 2, 3));
		send_word(word(CMD_PLAIN, 0, 1, 2, 4));
		send_word(begin_word(0, 100, 200, 300, 0, 0, 0));
		send_word(delta_word(2, 2, 2));
		send_word(delta_word($signed(TERMINATOR), 0, 0));
		send_word(word(CMD_PLAIN, 0, 32'sh80000000, 32'sh7FFFFFFF, 0));
		drain();

		while (words_sent < RANDOM_WORDS / 2)
			random_mix();
		drain();

		// Back-to-back words into a receiver that never stalls.
		steady = 1;
		rx_free = 1;
		while (words_sent < RANDOM_WORDS / 2 + STEADY_WORDS)
			random_mix();
		drain();
		steady = 0;
		rx_free = 0;

		while (words_sent < RANDOM_WORDS)
			random_mix();
		drain();

		$display("Sent %0d words of lines, plain runs and noise, with stalls and a gapless burst;",
			words_sent);
		$display("%0d vertices matched.", sb.matched);
		if (errors == 0 && sb.awaited.size() == 0)
			$display("TB_OK");
		else begin
			if (sb.awaited.size() != 0)
				report($sformatf("%0d vertices never arrived", sb.awaited.size()));
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire
